// File: rtl/core/baro_temp_pressure_compensation_unit_assert.svh
// Assertion macros shared by the compensation pipeline files.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BTP_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define BTP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: rtl/core/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared widths and register indexes for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpc_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TRIM       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_LAST = 2'd3;

   // quotient width of the restoring divider
   localparam int QUO_W = 32;

   // control carried beside the divider stages
   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [31:0] fine;
      logic [31:0] cent;
   } div_side_type;

endpackage

// File: rtl/core/btpc_divider.sv
// ----------------------------------------------------------------------------
// btpc_divider
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_unit_assert.svh"

module btpc_divider
   import btpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_dividend,
   input  logic [31:0]        in_divisor,
   input  logic               in_double,
   input  div_side_type       in_side,
   output logic               out_valid,
   output logic [31:0]        out_quotient,
   output logic               out_double,
   output div_side_type       out_side
);

   logic [QUO_W:0]    vld_ff;
   logic [31:0]       rem_ff  [QUO_W+1];
   logic [31:0]       quo_ff  [QUO_W+1];
   logic [31:0]       dvs_ff  [QUO_W+1];
   logic [QUO_W:0]    dbl_ff;
   div_side_type      side_ff [QUO_W+1];

   // stage 0 holds the operands; stage k+1 has quotient bit 31-k resolved
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= '0;
      quo_ff[0]  <= in_dividend;
      dvs_ff[0]  <= in_divisor;
      dbl_ff[0]  <= in_double;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] shifted;
      assign shifted = {rem_ff[k], quo_ff[k][31]};
      assign trial   = shifted - {1'b0, dvs_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (!trial[32]) begin
            rem_ff[k+1] <= trial[31:0];
            quo_ff[k+1] <= {quo_ff[k][30:0], 1'b1};
         end else begin
            rem_ff[k+1] <= shifted[31:0];
            quo_ff[k+1] <= {quo_ff[k][30:0], 1'b0};
         end
         dvs_ff[k+1]  <= dvs_ff[k];
         dbl_ff[k+1]  <= dbl_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid    = vld_ff[QUO_W];
   assign out_quotient = quo_ff[QUO_W];
   assign out_double   = dbl_ff[QUO_W];
   assign out_side     = side_ff[QUO_W];

   `BTP_ASSERT_NEXT(a_div_valid_flow, clock, reset, vld_ff[0], vld_ff[1], "divider lost a beat")
   `BTP_ASSERT_IMPL(a_div_side_match, clock, reset, out_valid, out_side.valid,
      "divider side data out of step")

endmodule

// File: rtl/core/baro_temp_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// 32-bit integer temperature and pressure compensation for a barometer.
// ----------------------------------------------------------------------------
// A new sample pair may be started every cycle (busy stays low). Each result
// appears on the rsp_ ports with rsp_valid for exactly one cycle, after it
// has passed 9 pipeline stages of multiply and add, a 33-stage
// pipelined restoring divider (operand register plus one stage per quotient
// bit), and 4 stages of final correction. The receiver cannot stall. Trim
// registers must only be written while no beat is in flight.
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_unit_assert.svh"

module baro_temp_pressure_compensation_unit
   import btpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [19:0]            req_raw_temperature,
   input  logic [19:0]            req_raw_pressure,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_fine_temp,
   output logic signed [31:0]     rsp_temp_centi,
   output logic [31:0]            rsp_pressure_pa,
   output logic                   rsp_divide_fault,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   function automatic logic [31:0] sra(input logic [31:0] x, input int s);
      sra = 32'($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] sx(input logic [15:0] v);
      sx = {{16{v[15]}}, v};
   endfunction

   // ---------------- configuration
   logic [47:0] temp_trim_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [15:0] p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         plo_ff       <= '0;
         phi_ff       <= '0;
         p9_ff        <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_TRIM:       temp_trim_ff <= csr_data[47:0];
            CSR_PRESS_TRIM_LOW:  plo_ff       <= csr_data;
            CSR_PRESS_TRIM_HIGH: phi_ff       <= csr_data;
            CSR_PRESS_TRIM_LAST: p9_ff        <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, temp_trim_ff[15:0]};
   assign t2 = sx(temp_trim_ff[31:16]);
   assign t3 = sx(temp_trim_ff[47:32]);
   assign p1 = {16'd0, plo_ff[15:0]};
   assign p2 = sx(plo_ff[31:16]);
   assign p3 = sx(plo_ff[47:32]);
   assign p4 = sx(plo_ff[63:48]);
   assign p5 = sx(phi_ff[15:0]);
   assign p6 = sx(phi_ff[31:16]);
   assign p7 = sx(phi_ff[47:32]);
   assign p8 = sx(phi_ff[63:48]);
   assign p9 = sx(p9_ff);

   assign busy = 1'b0;
   logic accept;
   assign accept = start & ~busy;

   // ---------------- S1: temperature differences
   logic        v1_ff;
   logic [31:0] x1_ff, d1_ff, ap1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
      x1_ff  <= {15'd0, req_raw_temperature[19:3]} - (t1 << 1);
      d1_ff  <= {16'd0, req_raw_temperature[19:4]} - t1;
      ap1_ff <= {12'd0, req_raw_pressure};
   end

   // ---------------- S2: products
   logic        v2_ff;
   logic [31:0] a2_ff, dd2_ff, ap2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      a2_ff  <= sra(32'(x1_ff * t2), 11);
      dd2_ff <= sra(32'(d1_ff * d1_ff), 12);
      ap2_ff <= ap1_ff;
   end

   // ---------------- S3: t3 term
   logic        v3_ff;
   logic [31:0] a3_ff, b3_ff, ap3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      a3_ff  <= a2_ff;
      b3_ff  <= sra(32'(dd2_ff * t3), 14);
      ap3_ff <= ap2_ff;
   end

   // ---------------- S4: fine temperature and pressure offset var
   logic        v4_ff;
   logic [31:0] fine4_ff, pa4_ff, ap4_ff;
   logic [31:0] fine3;
   assign fine3 = a3_ff + b3_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      fine4_ff <= fine3;
      pa4_ff   <= sra(fine3, 1) - 32'd64000;
      ap4_ff   <= ap3_ff;
   end

   // ---------------- S5: centidegree temperature and first products of pressure
   logic        v5_ff;
   logic [31:0] fine5_ff, cent5_ff, q5_ff, ap5_5_ff, p2a5_ff, ap5_ff;
   logic [31:0] qa4;
   assign qa4 = sra(pa4_ff, 2);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      fine5_ff <= fine4_ff;
      cent5_ff <= sra(32'(fine4_ff * 32'd5) + 32'd128, 8);
      q5_ff    <= 32'(qa4 * qa4);
      ap5_5_ff <= 32'(pa4_ff * p5) << 1;
      p2a5_ff  <= sra(32'(p2 * pa4_ff), 1);
      ap5_ff   <= ap4_ff;
   end

   // ---------------- S6: second products
   logic        v6_ff;
   logic [31:0] fine6_ff, cent6_ff, b6_ff, p3q6_ff, p2a6_ff, ap6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      fine6_ff <= fine5_ff;
      cent6_ff <= cent5_ff;
      b6_ff    <= 32'(sra(q5_ff, 11) * p6) + ap5_5_ff;
      p3q6_ff  <= sra(32'(p3 * sra(q5_ff, 13)), 3);
      p2a6_ff  <= p2a5_ff;
      ap6_ff   <= ap5_ff;
   end

   // ---------------- S7: sums
   logic        v7_ff;
   logic [31:0] fine7_ff, cent7_ff, b7_ff, a7_ff, ap7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
      fine7_ff <= fine6_ff;
      cent7_ff <= cent6_ff;
      b7_ff    <= sra(b6_ff, 2) + (p4 << 16);
      a7_ff    <= sra(p3q6_ff + p2a6_ff, 18);
      ap7_ff   <= ap6_ff;
   end

   // ---------------- S8: divisor product and dividend base
   logic        v8_ff;
   logic [31:0] fine8_ff, cent8_ff, dv8_ff, pb8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
      fine8_ff <= fine7_ff;
      cent8_ff <= cent7_ff;
      dv8_ff   <= sra(32'((32'd32768 + a7_ff) * p1), 15);
      pb8_ff   <= (32'd1048576 - ap7_ff) - sra(b7_ff, 12);
   end

   // ---------------- S9: times 3125
   logic        v9_ff;
   logic [31:0] fine9_ff, cent9_ff, dv9_ff, pm9_ff;
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else       v9_ff <= v8_ff;
      fine9_ff <= fine8_ff;
      cent9_ff <= cent8_ff;
      dv9_ff   <= dv8_ff;
      pm9_ff   <= 32'(pb8_ff * 32'd3125);
   end

   // ---------------- divider
   logic         dbl9;
   logic [31:0]  dend9;
   div_side_type side9, side_d;
   logic         vd, dbl_d;
   logic [31:0]  quo_d;

   assign dbl9  = pm9_ff[31];
   assign dend9 = dbl9 ? pm9_ff : (pm9_ff << 1);
   assign side9 = '{valid: v9_ff, fault: (dv9_ff == 32'd0), fine: fine9_ff, cent: cent9_ff};

   btpc_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v9_ff),
      .in_dividend  (dend9),
      .in_divisor   (dv9_ff),
      .in_double    (dbl9),
      .in_side      (side9),
      .out_valid    (vd),
      .out_quotient (quo_d),
      .out_double   (dbl_d),
      .out_side     (side_d)
   );

   // ---------------- C1: final pressure and square
   logic         vc1_ff;
   div_side_type sc1_ff;
   logic [31:0]  pc1_ff, qc1_ff;
   logic [31:0]  pq;
   assign pq = dbl_d ? (quo_d << 1) : quo_d;
   always_ff @(posedge clock) begin
      if (reset) vc1_ff <= 1'b0;
      else       vc1_ff <= vd;
      sc1_ff <= side_d;
      pc1_ff <= pq;
      qc1_ff <= 32'({3'd0, pq[31:3]} * {3'd0, pq[31:3]});
   end

   // ---------------- C2: p9 and p8 terms
   logic         vc2_ff;
   div_side_type sc2_ff;
   logic [31:0]  pc2_ff, ac2_ff, bc2_ff;
   always_ff @(posedge clock) begin
      if (reset) vc2_ff <= 1'b0;
      else       vc2_ff <= vc1_ff;
      sc2_ff <= sc1_ff;
      pc2_ff <= pc1_ff;
      ac2_ff <= sra(32'(p9 * {13'd0, qc1_ff[31:13]}), 12);
      bc2_ff <= sra(32'({2'd0, pc1_ff[31:2]} * p8), 13);
   end

   // ---------------- C3: correction sum
   logic         vc3_ff;
   div_side_type sc3_ff;
   logic [31:0]  pc3_ff, cc3_ff;
   always_ff @(posedge clock) begin
      if (reset) vc3_ff <= 1'b0;
      else       vc3_ff <= vc2_ff;
      sc3_ff <= sc2_ff;
      pc3_ff <= pc2_ff;
      cc3_ff <= sra(ac2_ff + bc2_ff + p7, 4);
   end

   // ---------------- C4: output register
   logic         rv_ff;
   div_side_type so_ff;
   logic [31:0]  po_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= vc3_ff;
      so_ff <= sc3_ff;
      po_ff <= sc3_ff.fault ? 32'd0 : (pc3_ff + cc3_ff);
   end

   assign rsp_valid        = rv_ff;
   assign rsp_fine_temp    = so_ff.fine;
   assign rsp_temp_centi   = so_ff.cent;
   assign rsp_pressure_pa  = po_ff;
   assign rsp_divide_fault = so_ff.fault;

   `BTP_ASSERT_IMPL(a_fault_zero, clock, reset, rsp_valid && rsp_divide_fault,
      rsp_pressure_pa == 32'd0, "fault beat with nonzero pressure")
   `BTP_ASSERT_NEXT(a_accept_flow, clock, reset, accept, v1_ff, "accepted beat dropped")
   `BTP_ASSERT_IMPL(a_out_side, clock, reset, rsp_valid, so_ff.valid,
      "output side data out of step")

endmodule
